### rtl/core/bsss_pkg.sv
`timescale 1ns / 1ps
package bsss_pkg;

	localparam int MAX_BANKS    = 255;
	localparam int MAX_PER_BANK = 4;

	localparam int ACC_W     = 20;
	localparam int SCNT_W    = 8;
	localparam int MEAN_W    = 12;
	localparam int DIV_CNT_W = $clog2(ACC_W + 1);

	// register indexes on the config port
	localparam logic [2:0] REG_BANK_COUNT  = 3'd0;
	localparam logic [2:0] REG_PER_BANK    = 3'd1;
	localparam logic [2:0] REG_TOTAL       = 3'd2;
	localparam logic [2:0] REG_SETTLE      = 3'd3;
	localparam logic [2:0] REG_SAMPLES     = 3'd4;
	localparam logic [2:0] REG_ADC_INPUT   = 3'd5;

	typedef enum logic [1:0] {
		FN_START  = 2'd0,
		FN_READ   = 2'd1,
		FN_TICK   = 2'd2,
		FN_SAMPLE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SETTLE  = 2'd1,
		PH_CONVERT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CS_IDLE  = 2'd0,
		CS_EXEC  = 2'd1,
		CS_DIV   = 2'd2,
		CS_WRITE = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
	} stat_t;

	typedef struct packed {
		logic [7:0]  n_banks;
		logic [2:0]  chans_per_bank;
		logic [9:0]  scan_len;
		logic [15:0] settle_ticks;
		logic [7:0]  samples_per_value;
	} cfg_t;

	// 12-bit mean to 16 bits, top nibble repeated at the bottom
	function automatic logic [15:0] widen(input logic [MEAN_W-1:0] m);
		return {m, m[MEAN_W-1:MEAN_W-4]};
	endfunction

endpackage

### rtl/core/bsss_div.sv
`timescale 1ns / 1ps
module bsss_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bsss_pkg::ACC_W-1:0]        dividend,
	input  logic [bsss_pkg::SCNT_W-1:0]       divisor,
	output logic                              busy,
	output logic [bsss_pkg::MEAN_W-1:0]       quotient
);
	import bsss_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SCNT_W-1:0]    den_q;
	logic [SCNT_W-1:0]    rem_q;
	logic [ACC_W-1:0]     quo_q;
	logic [SCNT_W:0]      trial;
	logic                 fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(ACC_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? SCNT_W'(trial - {1'b0, den_q}) : trial[SCNT_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q[MEAN_W-1:0];

endmodule

### rtl/core/bsss_ctrl.sv
`timescale 1ns / 1ps
module bsss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  bsss_pkg::stat_t stat,
	output bsss_pkg::cmd_t  cmd
);
	import bsss_pkg::*;

	ctrl_state_t state_q, state_n;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

	always_comb begin
		state_n      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = CS_EXEC;
				end
			end
			CS_EXEC: begin
				cmd.exec = 1'b1;
				state_n  = stat.need_div ? CS_DIV : CS_WRITE;
			end
			CS_DIV: begin
				if (!stat.div_busy) begin
					state_n = CS_WRITE;
				end
			end
			CS_WRITE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_n      = CS_IDLE;
				end
			end
			default: state_n = CS_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/bsss_dp.sv
`timescale 1ns / 1ps
module bsss_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  bsss_pkg::cmd_t  cmd,
	output bsss_pkg::stat_t stat,
	input  bsss_pkg::cfg_t  cfg,
	input  logic [1:0]      func,
	input  logic [7:0]      bank_sel,
	input  logic [1:0]      chan_sel,
	input  logic [11:0]     sample,
	output logic [7:0]      active_bank,
	output logic            bank_on,
	output logic [1:0]      mux_select,
	output logic            adc_start,
	output logic            value_valid,
	output logic [15:0]     value,
	output logic [9:0]      value_index,
	output logic            last_value,
	output logic [31:0]     scan_count,
	output logic            busy_res,
	output logic            error
);
	import bsss_pkg::*;

	// captured item
	func_t       func_q;
	logic [7:0]  bsel_q;
	logic [1:0]  csel_q;
	logic [11:0] smp_q;

	// sequencer state
	phase_t            phase_q, phase_n;
	logic              single_q, single_n;
	logic [7:0]        bank_q, bank_n;
	logic [1:0]        ch_q, ch_n;
	logic [9:0]        idx_q, idx_n;
	logic [15:0]       timer_q, timer_n;
	logic [SCNT_W-1:0] scnt_q, scnt_n;
	logic [ACC_W-1:0]  acc_q, acc_n;
	logic [31:0]       scan_q, scan_n;

	// per-item flags held until the result is loaded
	logic       p_adc_q, p_valid_q, p_last_q, p_err_q;
	logic [9:0] p_idx_q;
	logic       p_adc, p_valid, p_last, p_err;
	logic [9:0] p_idx;

	logic [7:0]        eff_banks;
	logic [2:0]        eff_per_bank;
	logic [7:0]        eff_samples;
	logic [ACC_W-1:0]  acc_sum;
	logic [SCNT_W-1:0] scnt_inc;
	logic [15:0]       timer_dec;
	logic [10:0]       nidx;
	logic [2:0]        nch;
	logic [8:0]        nbank;
	logic              do_select;
	logic              need_div;
	logic              div_busy;
	logic [MEAN_W-1:0] mean;

	assign eff_banks    = (32'(cfg.n_banks) > MAX_BANKS) ? 8'(MAX_BANKS) : cfg.n_banks;
	assign eff_per_bank = (32'(cfg.chans_per_bank) > MAX_PER_BANK) ?
		3'(MAX_PER_BANK) : cfg.chans_per_bank;
	assign eff_samples  = (cfg.samples_per_value == '0) ? 8'd1 : cfg.samples_per_value;

	assign acc_sum   = acc_q + ACC_W'(smp_q);
	assign scnt_inc  = scnt_q + 1'b1;
	assign timer_dec = timer_q - 1'b1;

	always_comb begin
		phase_n   = phase_q;
		single_n  = single_q;
		bank_n    = bank_q;
		ch_n      = ch_q;
		idx_n     = idx_q;
		timer_n   = timer_q;
		scnt_n    = scnt_q;
		acc_n     = acc_q;
		scan_n    = scan_q;
		p_adc     = 1'b0;
		p_valid   = 1'b0;
		p_idx     = '0;
		p_last    = 1'b0;
		p_err     = 1'b0;
		need_div  = 1'b0;
		do_select = 1'b0;
		nidx      = {1'b0, idx_q} + 11'd1;
		nch       = {1'b0, ch_q} + 3'd1;
		nbank     = {1'b0, bank_q};
		unique case (func_q)
			FN_START: begin
				if (phase_q == PH_IDLE) begin
					if (cfg.scan_len == '0 || eff_banks == '0 || eff_per_bank == '0) begin
						scan_n = scan_q + 1'b1;
					end else begin
						single_n  = 1'b0;
						bank_n    = '0;
						ch_n      = '0;
						idx_n     = '0;
						do_select = 1'b1;
					end
				end
			end
			FN_READ: begin
				if (phase_q == PH_IDLE) begin
					if (bsel_q >= eff_banks || {1'b0, csel_q} >= eff_per_bank) begin
						p_err = 1'b1;
					end else begin
						single_n  = 1'b1;
						bank_n    = bsel_q;
						ch_n      = csel_q;
						idx_n     = '0;
						do_select = 1'b1;
					end
				end
			end
			FN_TICK: begin
				if (phase_q == PH_SETTLE) begin
					timer_n = timer_dec;
					if (timer_dec == '0) begin
						phase_n = PH_CONVERT;
						p_adc   = 1'b1;
					end
				end
			end
			FN_SAMPLE: begin
				if (phase_q == PH_CONVERT) begin
					acc_n  = acc_sum;
					scnt_n = scnt_inc;
					if (scnt_inc < eff_samples) begin
						p_adc = 1'b1;
					end else begin
						need_div = 1'b1;
						p_valid  = 1'b1;
						p_idx    = idx_q;
						if (single_q) begin
							p_last   = 1'b1;
							phase_n  = PH_IDLE;
							single_n = 1'b0;
						end else begin
							if (nch >= eff_per_bank || nidx >= {1'b0, cfg.scan_len}) begin
								nch   = '0;
								nbank = {1'b0, bank_q} + 9'd1;
							end
							idx_n = nidx[9:0];
							if (nidx >= {1'b0, cfg.scan_len} || nbank >= {1'b0, eff_banks}) begin
								p_last  = 1'b1;
								phase_n = PH_IDLE;
								scan_n  = scan_q + 1'b1;
							end else begin
								ch_n      = nch[1:0];
								bank_n    = nbank[7:0];
								do_select = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		// select of a new bank or channel restarts settling, or goes straight to conversion when the settle time is zero
		if (do_select) begin
			timer_n = cfg.settle_ticks;
			scnt_n  = '0;
			acc_n   = '0;
			if (cfg.settle_ticks == '0) begin
				phase_n = PH_CONVERT;
				p_adc   = 1'b1;
			end else begin
				phase_n = PH_SETTLE;
			end
		end
	end

	bsss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && need_div),
		.dividend (acc_sum),
		.divisor  (scnt_inc),
		.busy     (div_busy),
		.quotient (mean)
	);

	assign stat.need_div = need_div;
	assign stat.div_busy = div_busy;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(func);
			bsel_q <= bank_sel;
			csel_q <= chan_sel;
			smp_q  <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			single_q  <= 1'b0;
			bank_q    <= '0;
			ch_q      <= '0;
			idx_q     <= '0;
			timer_q   <= '0;
			scnt_q    <= '0;
			acc_q     <= '0;
			scan_q    <= '0;
			p_adc_q   <= 1'b0;
			p_valid_q <= 1'b0;
			p_idx_q   <= '0;
			p_last_q  <= 1'b0;
			p_err_q   <= 1'b0;
		end else if (cmd.exec) begin
			phase_q   <= phase_n;
			single_q  <= single_n;
			bank_q    <= bank_n;
			ch_q      <= ch_n;
			idx_q     <= idx_n;
			timer_q   <= timer_n;
			scnt_q    <= scnt_n;
			acc_q     <= acc_n;
			scan_q    <= scan_n;
			p_adc_q   <= p_adc;
			p_valid_q <= p_valid;
			p_idx_q   <= p_idx;
			p_last_q  <= p_last;
			p_err_q   <= p_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bank <= '0;
			bank_on     <= 1'b0;
			mux_select  <= '0;
			adc_start   <= 1'b0;
			value_valid <= 1'b0;
			value       <= '0;
			value_index <= '0;
			last_value  <= 1'b0;
			scan_count  <= '0;
			busy_res    <= 1'b0;
			error       <= 1'b0;
		end else if (cmd.out_load) begin
			active_bank <= (phase_q != PH_IDLE) ? bank_q : 8'd0;
			bank_on     <= phase_q != PH_IDLE;
			mux_select  <= ch_q;
			adc_start   <= p_adc_q;
			value_valid <= p_valid_q;
			value       <= p_valid_q ? widen(mean) : 16'd0;
			value_index <= p_idx_q;
			last_value  <= p_last_q;
			scan_count  <= scan_q;
			busy_res    <= phase_q != PH_IDLE;
			error       <= p_err_q;
		end
	end

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(scan_q) |-> scan_q == $past(scan_q) + 32'd1)
		else $error("scan counter moved by other than one");

	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		error |-> !value_valid && !adc_start)
		else $error("error item carries a value or conversion request");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_value |-> value_valid)
		else $error("last flag without a value");

	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !div_busy)
		else $error("result loaded while divider still running");

endmodule

### rtl/core/banked_sensor_scan_sequencer.sv
`timescale 1ns / 1ps
// sequence: an item is captured, executed and its result loaded into the output register once it has room; an
// item that finishes a sensor value also waits on the bit-serial mean divider before its result is loaded
// flow: one item at a time, a new item is taken once the result is loaded,
// while the output register drains
// reset: arst_n clears sequencer state, scan count and output valid at once;
// config registers return to 1, 4, 4, 0, 1, 0
module banked_sensor_scan_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  bank_sel,
	input  logic [1:0]  chan_sel,
	input  logic [11:0] sample,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  active_bank,
	output logic        bank_on,
	output logic [1:0]  mux_select,
	output logic        adc_start,
	output logic        value_valid,
	output logic [15:0] value,
	output logic [9:0]  value_index,
	output logic        last_value,
	output logic [31:0] scan_count,
	output logic        busy_res,
	output logic        error
);
	import bsss_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] adc_input_q;
	logic       wr_en;
	cmd_t       cmd;
	stat_t      stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n_banks           <= 8'd1;
			cfg_q.chans_per_bank    <= 3'd4;
			cfg_q.scan_len          <= 10'd4;
			cfg_q.settle_ticks      <= 16'd0;
			cfg_q.samples_per_value <= 8'd1;
			adc_input_q             <= 2'd0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_BANK_COUNT: cfg_q.n_banks           <= pwdata[7:0];
				REG_PER_BANK:   cfg_q.chans_per_bank    <= pwdata[2:0];
				REG_TOTAL:      cfg_q.scan_len          <= pwdata[9:0];
				REG_SETTLE:     cfg_q.settle_ticks      <= pwdata[15:0];
				REG_SAMPLES:    cfg_q.samples_per_value <= pwdata[7:0];
				REG_ADC_INPUT:  adc_input_q             <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_BANK_COUNT: prdata = 32'(cfg_q.n_banks);
			REG_PER_BANK:   prdata = 32'(cfg_q.chans_per_bank);
			REG_TOTAL:      prdata = 32'(cfg_q.scan_len);
			REG_SETTLE:     prdata = 32'(cfg_q.settle_ticks);
			REG_SAMPLES:    prdata = 32'(cfg_q.samples_per_value);
			REG_ADC_INPUT:  prdata = 32'(adc_input_q);
			default:        prdata = 32'd0;
		endcase
	end

	bsss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bsss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg_q),
		.func        (func),
		.bank_sel    (bank_sel),
		.chan_sel    (chan_sel),
		.sample      (sample),
		.active_bank (active_bank),
		.bank_on     (bank_on),
		.mux_select  (mux_select),
		.adc_start   (adc_start),
		.value_valid (value_valid),
		.value       (value),
		.value_index (value_index),
		.last_value  (last_value),
		.scan_count  (scan_count),
		.busy_res    (busy_res),
		.error       (error)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import bsss_pkg::*;

	typedef struct packed {
		logic [7:0]  bank;
		logic        on;
		logic [1:0]  mux;
		logic        start;
		logic        vld;
		logic [15:0] val;
		logic [9:0]  vidx;
		logic        last;
		logic [31:0] scans;
		logic        busy;
		logic        err;
	} seq_out_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  ridx;
		logic [31:0] rval;
		func_t       fn;
		logic [7:0]  bsel;
		logic [1:0]  csel;
		logic [11:0] smp;
		bit          typed;
		seq_out_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [7:0]  bank_sel = '0;
	logic [1:0]  chan_sel = '0;
	logic [11:0] sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  active_bank;
	logic        bank_on;
	logic [1:0]  mux_select;
	logic        adc_start;
	logic        value_valid;
	logic [15:0] value;
	logic [9:0]  value_index;
	logic        last_value;
	logic [31:0] scan_count;
	logic        busy_res;
	logic        error;

	banked_sensor_scan_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .bank_sel(bank_sel),
		.chan_sel(chan_sel), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall), .active_bank(active_bank),
		.bank_on(bank_on), .mux_select(mux_select), .adc_start(adc_start),
		.value_valid(value_valid), .value(value), .value_index(value_index),
		.last_value(last_value), .scan_count(scan_count), .busy_res(busy_res),
		.error(error)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// register copies
	logic [7:0]  cfg_banks = 8'd1;
	logic [2:0]  cfg_per = 3'd4;
	logic [9:0]  cfg_total = 10'd4;
	logic [15:0] cfg_settle = 16'd0;
	logic [7:0]  cfg_samples = 8'd1;
	logic [1:0]  cfg_adc = 2'd0;

	// sequencer state copies
	phase_t      seq_phase = PH_IDLE;
	bit          one_shot = 1'b0;
	logic [7:0]  bank_ctr = '0;
	logic [1:0]  chan_ctr = '0;
	logic [9:0]  idx_ctr = '0;
	logic [15:0] settle_ctr = '0;
	logic [7:0]  smp_ctr = '0;
	logic [19:0] acc = '0;
	logic [31:0] scans = '0;

	seq_out_t pending_outputs[$];
	row_t     stim_rows[$];
	int       mismatches = 0;
	int       n_results = 0;
	bit       calm = 1'b0;

	function automatic int per_eff();
		return (cfg_per > MAX_PER_BANK) ? MAX_PER_BANK : int'(cfg_per);
	endfunction

	function automatic int samples_eff();
		return (cfg_samples == 0) ? 1 : int'(cfg_samples);
	endfunction

	function automatic bit select_channel();
		settle_ctr = cfg_settle;
		smp_ctr = '0;
		acc = '0;
		if (settle_ctr == 0) begin
			seq_phase = PH_CONVERT;
			return 1'b1;
		end
		seq_phase = PH_SETTLE;
		return 1'b0;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_BANK_COUNT: cfg_banks = val[7:0];
			REG_PER_BANK: cfg_per = val[2:0];
			REG_TOTAL: cfg_total = val[9:0];
			REG_SETTLE: cfg_settle = val[15:0];
			REG_SAMPLES: cfg_samples = val[7:0];
			REG_ADC_INPUT: cfg_adc = val[1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] reg_value(logic [2:0] idx);
		case (idx)
			REG_BANK_COUNT: return 32'(cfg_banks);
			REG_PER_BANK: return 32'(cfg_per);
			REG_TOTAL: return 32'(cfg_total);
			REG_SETTLE: return 32'(cfg_settle);
			REG_SAMPLES: return 32'(cfg_samples);
			REG_ADC_INPUT: return 32'(cfg_adc);
			default: return 32'd0;
		endcase
	endfunction

	function automatic seq_out_t sequencer_step(func_t fn, logic [7:0] bsel, logic [1:0] csel,
			logic [11:0] smp);
		seq_out_t r;
		int nidx, nch, nbank, mean;
		logic [11:0] m;
		r = '0;
		case (fn)
			FN_START: begin
				if (seq_phase == PH_IDLE) begin
					if (cfg_total == 0 || cfg_banks == 0 || per_eff() == 0) begin
						scans = scans + 32'd1;
					end else begin
						one_shot = 1'b0;
						bank_ctr = '0;
						chan_ctr = '0;
						idx_ctr = '0;
						r.start = select_channel();
					end
				end
			end
			FN_READ: begin
				if (seq_phase == PH_IDLE) begin
					if (bsel >= cfg_banks || csel >= per_eff()) begin
						r.err = 1'b1;
					end else begin
						one_shot = 1'b1;
						bank_ctr = bsel;
						chan_ctr = csel;
						idx_ctr = '0;
						r.start = select_channel();
					end
				end
			end
			FN_TICK: begin
				if (seq_phase == PH_SETTLE) begin
					settle_ctr = settle_ctr - 16'd1;
					if (settle_ctr == 0) begin
						seq_phase = PH_CONVERT;
						r.start = 1'b1;
					end
				end
			end
			default: begin
				if (seq_phase == PH_CONVERT) begin
					acc = acc + smp;
					smp_ctr = smp_ctr + 8'd1;
					if (smp_ctr < samples_eff()) begin
						r.start = 1'b1;
					end else begin
						mean = (smp_ctr != 0) ? int'(acc / smp_ctr) : 0;
						m = mean[11:0];
						r.vld = 1'b1;
						r.val = {m, m[11:8]};
						r.vidx = idx_ctr;
						if (one_shot) begin
							r.last = 1'b1;
							seq_phase = PH_IDLE;
							one_shot = 1'b0;
						end else begin
							nidx = idx_ctr + 1;
							nch = chan_ctr + 1;
							nbank = int'(bank_ctr);
							// bank steps on when its channels or the scan run out
							if (nch >= per_eff() || nidx >= cfg_total) begin
								nch = 0;
								nbank = bank_ctr + 1;
							end
							if (nidx >= cfg_total || nbank >= cfg_banks) begin
								r.last = 1'b1;
								seq_phase = PH_IDLE;
								scans = scans + 32'd1;
								idx_ctr = nidx[9:0];
							end else begin
								idx_ctr = nidx[9:0];
								chan_ctr = nch[1:0];
								bank_ctr = nbank[7:0];
								r.start = select_channel();
							end
						end
					end
				end
			end
		endcase
		r.busy = (seq_phase != PH_IDLE);
		r.on = r.busy;
		r.bank = r.busy ? bank_ctr : 8'd0;
		r.mux = chan_ctr;
		r.scans = scans;
		return r;
	endfunction

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic logic [11:0] draw_sample();
		int k;
		k = $urandom_range(0, 7);
		if (k == 0)
			return 12'd0;
		if (k == 1)
			return 12'hFFF;
		return 12'($urandom_range(0, 4095));
	endfunction

	function automatic row_t item_row(func_t fn, logic [7:0] b, logic [1:0] c, logic [11:0] s);
		row_t r;
		r.kind = ROW_ITEM;
		r.ridx = '0;
		r.rval = '0;
		r.fn = fn;
		r.bsel = b;
		r.csel = c;
		r.smp = s;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t typed_row(func_t fn, logic [7:0] b, logic [1:0] c, logic [11:0] s,
			seq_out_t w);
		row_t r;
		r = item_row(fn, b, c, s);
		r.typed = 1'b1;
		r.want = w;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] val);
		row_t r;
		r = item_row(FN_TICK, 8'd0, 2'd0, 12'd0);
		r.kind = ROW_CFG;
		r.ridx = idx;
		r.rval = val;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < 50)
			$display("mismatch at result %0d: %s", n_results, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic send_item(func_t fn, logic [7:0] b, logic [1:0] c, logic [11:0] s,
			bit typed, seq_out_t want);
		int gap;
		seq_out_t pred;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = fn;
		bank_sel = b;
		chan_sel = c;
		sample = s;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pred = sequencer_step(fn, b, c, s);
		pending_outputs.push_back(typed ? want : pred);
	endtask

	// hold the input side until every pending result has come out
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		drain();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		apply_reg(idx, val);
		// read back the register just written
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (pready)
			check_field("register readback", prdata, reg_value(idx));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic send_noise();
		send_item(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
			2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)), 1'b0, '0);
	endtask

	always @(posedge clk) begin : result_check
		seq_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("result with no item pending");
			end else begin
				want = pending_outputs.pop_front();
				check_field("active_bank", 32'(active_bank), 32'(want.bank));
				check_field("bank_on", 32'(bank_on), 32'(want.on));
				check_field("mux_select", 32'(mux_select), 32'(want.mux));
				check_field("adc_start", 32'(adc_start), 32'(want.start));
				check_field("value_valid", 32'(value_valid), 32'(want.vld));
				check_field("value", 32'(value), 32'(want.val));
				check_field("value_index", 32'(value_index), 32'(want.vidx));
				check_field("last_value", 32'(last_value), 32'(want.last));
				check_field("scan_count", scan_count, want.scans);
				check_field("busy_res", 32'(busy_res), 32'(want.busy));
				check_field("error", 32'(error), 32'(want.err));
			end
			n_results++;
		end
	end

	// receiver side stalls
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = draw_wait();
			@(negedge clk);
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		seq_out_t w;
		int rnd_items;
		int k;
		bit mid;
		logic [31:0] b, per, tot, st, sp;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, reset settings first
		w = '0;
		stim_rows.push_back(typed_row(FN_TICK, 8'd0, 2'd0, 12'd0, w));
		w.err = 1'b1;
		stim_rows.push_back(typed_row(FN_READ, 8'd255, 2'd3, 12'd0, w));
		w = '0;
		w.on = 1'b1;
		w.mux = 2'd3;
		w.start = 1'b1;
		w.busy = 1'b1;
		stim_rows.push_back(typed_row(FN_READ, 8'd0, 2'd3, 12'd0, w));
		w = '0;
		w.mux = 2'd3;
		w.vld = 1'b1;
		w.val = 16'hFFFF;
		w.last = 1'b1;
		stim_rows.push_back(typed_row(FN_SAMPLE, 8'd0, 2'd0, 12'hFFF, w));
		stim_rows.push_back(item_row(FN_START, 8'd0, 2'd0, 12'd0));
		// commands while busy and a tick during conversion are ignored
		stim_rows.push_back(item_row(FN_READ, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_TICK, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd255, 2'd3, 12'd0));
		stim_rows.push_back(item_row(FN_START, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'hFFF));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'h800));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'd1));
		// empty scan, channel count above the mux range
		stim_rows.push_back(cfg_row(REG_BANK_COUNT, 32'd0));
		stim_rows.push_back(cfg_row(REG_PER_BANK, 32'd7));
		stim_rows.push_back(cfg_row(REG_ADC_INPUT, 32'd3));
		stim_rows.push_back(item_row(FN_START, 8'd0, 2'd0, 12'd0));
		// scan cut short by bank capacity, settle of one tick, sample count zero
		stim_rows.push_back(cfg_row(REG_BANK_COUNT, 32'd2));
		stim_rows.push_back(cfg_row(REG_PER_BANK, 32'd2));
		stim_rows.push_back(cfg_row(REG_TOTAL, 32'd1023));
		stim_rows.push_back(cfg_row(REG_SETTLE, 32'd1));
		stim_rows.push_back(cfg_row(REG_SAMPLES, 32'd0));
		stim_rows.push_back(item_row(FN_START, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'd5));
		stim_rows.push_back(item_row(FN_TICK, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'h123));
		// averaging depth changed mid scan
		stim_rows.push_back(cfg_row(REG_SAMPLES, 32'd2));
		stim_rows.push_back(item_row(FN_TICK, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'hFFF));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'hFFE));
		stim_rows.push_back(item_row(FN_TICK, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'd3));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_TICK, 8'd0, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'hABC));
		stim_rows.push_back(item_row(FN_SAMPLE, 8'd0, 2'd0, 12'h543));
		stim_rows.push_back(cfg_row(REG_SETTLE, 32'd65535));
		stim_rows.push_back(item_row(FN_READ, 8'd2, 2'd0, 12'd0));
		stim_rows.push_back(item_row(FN_TICK, 8'd0, 2'd0, 12'd0));

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				write_reg(stim_rows[i].ridx, stim_rows[i].rval);
			else
				send_item(stim_rows[i].fn, stim_rows[i].bsel, stim_rows[i].csel,
					stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].want);
		end

		// deepest average of full-scale samples
		write_reg(REG_BANK_COUNT, 32'd1);
		write_reg(REG_PER_BANK, 32'd1);
		write_reg(REG_TOTAL, 32'd1);
		write_reg(REG_SETTLE, 32'd0);
		write_reg(REG_SAMPLES, 32'd255);
		send_item(FN_READ, 8'd0, 2'd0, 12'd0, 1'b0, '0);
		repeat (255) send_item(FN_SAMPLE, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
			12'hFFF, 1'b0, '0);

		// full capacity scan with no idling
		write_reg(REG_BANK_COUNT, 32'd255);
		write_reg(REG_PER_BANK, 32'd4);
		write_reg(REG_TOTAL, 32'd1020);
		write_reg(REG_SAMPLES, 32'd1);
		write_reg(REG_ADC_INPUT, 32'd2);
		calm = 1'b1;
		send_item(FN_START, 8'd0, 2'd0, 12'd0, 1'b0, '0);
		while (seq_phase != PH_IDLE)
			send_item(FN_SAMPLE, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
				draw_sample(), 1'b0, '0);
		calm = 1'b0;

		rnd_items = 0;
		while (rnd_items < 300) begin
			if ($urandom_range(0, 2) == 0) begin
				k = $urandom_range(0, 9);
				b = (k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(1, 4);
				per = $urandom_range(0, 7);
				tot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
				if (b > 4 && tot > 12)
					tot = $urandom_range(0, 12);
				st = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
				sp = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
				write_reg(REG_BANK_COUNT, b);
				write_reg(REG_PER_BANK, per);
				write_reg(REG_TOTAL, tot);
				write_reg(REG_SETTLE, st);
				write_reg(REG_SAMPLES, sp);
				write_reg(REG_ADC_INPUT, $urandom_range(0, 3));
			end
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) == 0)
				send_noise();
			if ($urandom_range(0, 1) == 0) begin
				send_item(FN_START, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
					12'($urandom_range(0, 4095)), 1'b0, '0);
			end else begin
				b = ($urandom_range(0, 3) == 0 || cfg_banks == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, cfg_banks - 1);
				per = ($urandom_range(0, 3) == 0 || per_eff() == 0) ? $urandom_range(0, 3) :
					$urandom_range(0, per_eff() - 1);
				send_item(FN_READ, b[7:0], per[1:0], 12'($urandom_range(0, 4095)), 1'b0, '0);
			end
			rnd_items++;
			mid = ($urandom_range(0, 15) == 0);
			while (seq_phase != PH_IDLE) begin
				if (mid && $urandom_range(0, 3) == 0) begin
					// registers touched while a scan is under way
					mid = 1'b0;
					case ($urandom_range(0, 5))
						0: write_reg(REG_BANK_COUNT, $urandom_range(0, 4));
						1: write_reg(REG_PER_BANK, $urandom_range(0, 7));
						2: write_reg(REG_TOTAL, $urandom_range(0, 12));
						3: write_reg(REG_SETTLE, $urandom_range(0, 3));
						4: write_reg(REG_SAMPLES, $urandom_range(0, 4));
						default: write_reg(REG_ADC_INPUT, $urandom_range(0, 3));
					endcase
				end
				if ($urandom_range(0, 9) == 0) begin
					send_noise();
				end else begin
					send_item((seq_phase == PH_SETTLE) ? FN_TICK : FN_SAMPLE,
						8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), draw_sample(),
						1'b0, '0);
					rnd_items++;
				end
			end
		end

		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (pending_outputs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
